### hw/rtl/rhd_pkg.sv
// Shared types and constants for the RTP H.264 depacketizer.
package rhd_pkg;

  localparam int ADDR_BITS  = 20;
  localparam int CFG_BITS   = 20;
  localparam int OUT_ADDR_BITS = 20;
  localparam int CMP_BITS   = (ADDR_BITS > CFG_BITS) ? ADDR_BITS : CFG_BITS;
  localparam int SEQ_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int NUM_SLOTS  = 8;

  localparam logic [CFG_BITS-1:0] FRAME_LIMIT_RESET = CFG_BITS'(524288);
  localparam logic [4:0] SINGLE_TYPE_MAX = 5'd23;
  localparam logic [4:0] FU_A_TYPE       = 5'd28;
  localparam logic [4:0] IDR_TYPE        = 5'd5;

  // Fixed slot order of the results one item can cause
  localparam int SLOT_LOSE  = 0;
  localparam int SLOT_DROP  = 1;
  localparam int SLOT_WRITE = 2;
  localparam int SLOT_END   = 6;
  localparam int SLOT_CLEAR = 7;

  typedef enum logic [1:0] {
    EV_WRITE  = 2'd0,
    EV_REWIND = 2'd1,
    EV_READY  = 2'd2,
    EV_ERROR  = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORBIDDEN = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_FRAGMENT  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef struct packed {
    event_kind_t          kind;
    logic [7:0]           data;
    logic [ADDR_BITS-1:0] addr;
    status_t              stat;
  } event_t;

  typedef struct packed {
    event_t [NUM_SLOTS-1:0]  slots;
    logic                    intra;
    logic [COUNT_BITS-1:0]   key_count;
    logic [COUNT_BITS-1:0]   lost_count;
  } event_set_t;

endpackage

### hw/rtl/rhd_parser.sv
// Packet parser: depacketizer state and the result set for one payload byte.
module rhd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    payload_byte,
  input  logic                          first_byte,
  input  logic                          last_byte,
  input  logic [rhd_pkg::SEQ_BITS-1:0]  sequence_number,
  input  logic                          marker_bit,
  input  logic                          cfg_write,
  input  logic [rhd_pkg::CFG_BITS-1:0]  cfg_data,
  output rhd_pkg::event_set_t           ev_set,
  output logic [rhd_pkg::NUM_SLOTS-1:0] ev_mask
);

  typedef enum logic [1:0] {
    POS_IDLE      = 2'd0,
    POS_FU_HEADER = 2'd1,
    POS_PAYLOAD   = 2'd2
  } pos_t;

  logic [rhd_pkg::CFG_BITS-1:0]   max_frame_bytes;
  logic [rhd_pkg::ADDR_BITS-1:0]  write_pointer, write_pointer_next;
  logic [rhd_pkg::ADDR_BITS-1:0]  fragment_start, fragment_start_next;
  logic                           in_fragment, in_fragment_next;
  logic [rhd_pkg::SEQ_BITS-1:0]   fragment_seq, fragment_seq_next;
  logic                           seen_keyframe, seen_keyframe_next;
  logic [rhd_pkg::COUNT_BITS-1:0] key_counter, key_counter_next;
  logic [rhd_pkg::COUNT_BITS-1:0] lost_counter, lost_counter_next;
  pos_t                           byte_position, byte_position_next;
  logic                           packet_dropped, packet_dropped_next;
  logic [7:0]                     indicator_bits, indicator_bits_next;
  logic                           packet_intra, packet_intra_next;

  logic [4:0]                    nal_type;
  logic                          lose, drop, wr_hdr, wr_byte, fin, hdr_ok;
  logic                          lost_inc, frag_open, start_frag;
  rhd_pkg::status_t              drop_code, end_code;
  logic [7:0]                    hdr;
  logic                          end_err, ready, clear;
  logic [rhd_pkg::ADDR_BITS-1:0] wp0, wp_w;

  assign nal_type = payload_byte[4:0];

  always_comb begin
    lose = 1'b0;
    drop = 1'b0;
    drop_code = rhd_pkg::ST_OK;
    wr_hdr = 1'b0;
    wr_byte = 1'b0;
    fin = 1'b0;
    hdr_ok = 1'b0;
    lost_inc = 1'b0;
    start_frag = 1'b0;
    frag_open = in_fragment;
    hdr = payload_byte;
    byte_position_next = byte_position;
    packet_dropped_next = packet_dropped;
    indicator_bits_next = indicator_bits;
    packet_intra_next = packet_intra;
    fragment_seq_next = fragment_seq;

    if (first_byte) begin
      packet_dropped_next = 1'b0;
      packet_intra_next = 1'b0;
      byte_position_next = POS_IDLE;
      indicator_bits_next = payload_byte;
      if (payload_byte[7]) begin
        drop = 1'b1;
        drop_code = rhd_pkg::ST_FORBIDDEN;
      end else begin
        // a non-FU packet abandons the open fragment
        if (in_fragment && nal_type != rhd_pkg::FU_A_TYPE) begin
          lose = 1'b1;
          frag_open = 1'b0;
        end
        if (nal_type >= 5'd1 && nal_type <= rhd_pkg::SINGLE_TYPE_MAX) begin
          packet_intra_next = (nal_type == rhd_pkg::IDR_TYPE);
          wr_hdr = 1'b1;
          byte_position_next = POS_PAYLOAD;
          fin = last_byte;
        end else if (nal_type == rhd_pkg::FU_A_TYPE) begin
          if (last_byte) begin
            drop = 1'b1;
            drop_code = rhd_pkg::ST_TRUNCATED;
          end else begin
            byte_position_next = POS_FU_HEADER;
          end
        end else begin
          drop = 1'b1;
          drop_code = rhd_pkg::ST_UNKNOWN;
        end
      end
    end else if (!packet_dropped && byte_position == POS_FU_HEADER) begin
      hdr = {1'b0, indicator_bits[6:5], payload_byte[4:0]};
      if (payload_byte[7]) begin
        if (in_fragment) begin
          lose = 1'b1;
          drop = 1'b1;
          drop_code = rhd_pkg::ST_FRAGMENT;
        end else begin
          start_frag = 1'b1;
          frag_open = 1'b1;
          packet_intra_next = (nal_type == rhd_pkg::IDR_TYPE);
          wr_hdr = 1'b1;
          hdr_ok = 1'b1;
        end
      end else if (!in_fragment) begin
        lost_inc = 1'b1;
        drop = 1'b1;
        drop_code = rhd_pkg::ST_FRAGMENT;
      end else if (rhd_pkg::SEQ_BITS'(sequence_number - fragment_seq) !=
                   rhd_pkg::SEQ_BITS'(1)) begin
        lose = 1'b1;
        frag_open = 1'b0;
        drop = 1'b1;
        drop_code = rhd_pkg::ST_FRAGMENT;
      end else begin
        hdr_ok = 1'b1;
      end
      if (hdr_ok) begin
        if (payload_byte[6]) begin
          frag_open = 1'b0;
        end
        fragment_seq_next = sequence_number;
        byte_position_next = POS_PAYLOAD;
        fin = last_byte;
      end
    end else if (!packet_dropped && byte_position == POS_PAYLOAD) begin
      wr_byte = 1'b1;
      fin = last_byte;
    end

    if (drop) begin
      packet_dropped_next = 1'b1;
      byte_position_next = POS_IDLE;
    end
    if (last_byte) begin
      byte_position_next = POS_IDLE;
    end
  end

  // Addresses and end-of-packet handling
  always_comb begin
    wp0 = lose ? fragment_start : write_pointer;
    if (wr_hdr) begin
      wp_w = wp0 + rhd_pkg::ADDR_BITS'(4);
    end else if (wr_byte) begin
      wp_w = wp0 + rhd_pkg::ADDR_BITS'(1);
    end else begin
      wp_w = wp0;
    end
    seen_keyframe_next = seen_keyframe | (fin & packet_intra_next);
    key_counter_next = key_counter + rhd_pkg::COUNT_BITS'(fin & packet_intra_next);
    lost_counter_next = lost_counter + rhd_pkg::COUNT_BITS'(lose | lost_inc);
    end_err = 1'b0;
    ready = 1'b0;
    clear = 1'b0;
    end_code = rhd_pkg::ST_OK;
    if (fin) begin
      if (!marker_bit) begin
        if (rhd_pkg::CMP_BITS'(wp_w) > rhd_pkg::CMP_BITS'(max_frame_bytes)) begin
          end_err = 1'b1;
          end_code = rhd_pkg::ST_OVERFLOW;
          clear = 1'b1;
        end
      end else begin
        clear = 1'b1;
        if (frag_open) begin
          end_err = 1'b1;
          end_code = rhd_pkg::ST_FRAGMENT;
        end else if (seen_keyframe_next) begin
          ready = 1'b1;
        end
      end
    end
    write_pointer_next = clear ? '0 : wp_w;
    in_fragment_next = clear ? 1'b0 : frag_open;
    fragment_start_next = start_frag ? write_pointer : fragment_start;
  end

  // Assemble the result slots
  always_comb begin
    ev_set = '0;
    ev_set.slots[rhd_pkg::SLOT_LOSE].kind = rhd_pkg::EV_REWIND;
    ev_set.slots[rhd_pkg::SLOT_LOSE].addr = fragment_start;
    ev_set.slots[rhd_pkg::SLOT_DROP].kind = rhd_pkg::EV_ERROR;
    ev_set.slots[rhd_pkg::SLOT_DROP].stat = drop_code;
    ev_set.slots[rhd_pkg::SLOT_WRITE].kind = rhd_pkg::EV_WRITE;
    ev_set.slots[rhd_pkg::SLOT_WRITE].data = wr_hdr ? 8'd0 : payload_byte;
    ev_set.slots[rhd_pkg::SLOT_WRITE].addr = wp0;
    ev_set.slots[rhd_pkg::SLOT_WRITE+1].kind = rhd_pkg::EV_WRITE;
    ev_set.slots[rhd_pkg::SLOT_WRITE+1].data = 8'd0;
    ev_set.slots[rhd_pkg::SLOT_WRITE+1].addr = wp0 + rhd_pkg::ADDR_BITS'(1);
    ev_set.slots[rhd_pkg::SLOT_WRITE+2].kind = rhd_pkg::EV_WRITE;
    ev_set.slots[rhd_pkg::SLOT_WRITE+2].data = 8'd1;
    ev_set.slots[rhd_pkg::SLOT_WRITE+2].addr = wp0 + rhd_pkg::ADDR_BITS'(2);
    ev_set.slots[rhd_pkg::SLOT_WRITE+3].kind = rhd_pkg::EV_WRITE;
    ev_set.slots[rhd_pkg::SLOT_WRITE+3].data = hdr;
    ev_set.slots[rhd_pkg::SLOT_WRITE+3].addr = wp0 + rhd_pkg::ADDR_BITS'(3);
    if (end_err) begin
      ev_set.slots[rhd_pkg::SLOT_END].kind = rhd_pkg::EV_ERROR;
      ev_set.slots[rhd_pkg::SLOT_END].stat = end_code;
    end else begin
      ev_set.slots[rhd_pkg::SLOT_END].kind = rhd_pkg::EV_READY;
      ev_set.slots[rhd_pkg::SLOT_END].addr = wp_w;
    end
    ev_set.slots[rhd_pkg::SLOT_CLEAR].kind = rhd_pkg::EV_REWIND;
    ev_set.intra = packet_intra_next;
    ev_set.key_count = key_counter_next;
    ev_set.lost_count = lost_counter_next;

    ev_mask = '0;
    ev_mask[rhd_pkg::SLOT_LOSE] = lose;
    ev_mask[rhd_pkg::SLOT_DROP] = drop;
    ev_mask[rhd_pkg::SLOT_WRITE] = wr_hdr | wr_byte;
    ev_mask[rhd_pkg::SLOT_WRITE+1] = wr_hdr;
    ev_mask[rhd_pkg::SLOT_WRITE+2] = wr_hdr;
    ev_mask[rhd_pkg::SLOT_WRITE+3] = wr_hdr;
    ev_mask[rhd_pkg::SLOT_END] = end_err | ready;
    ev_mask[rhd_pkg::SLOT_CLEAR] = clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= rhd_pkg::FRAME_LIMIT_RESET;
      write_pointer <= '0;
      fragment_start <= '0;
      in_fragment <= 1'b0;
      fragment_seq <= '0;
      seen_keyframe <= 1'b0;
      key_counter <= '0;
      lost_counter <= '0;
      byte_position <= POS_IDLE;
      packet_dropped <= 1'b0;
      indicator_bits <= '0;
      packet_intra <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_frame_bytes <= cfg_data;
      end
      if (take) begin
        write_pointer <= write_pointer_next;
        fragment_start <= fragment_start_next;
        in_fragment <= in_fragment_next;
        fragment_seq <= fragment_seq_next;
        seen_keyframe <= seen_keyframe_next;
        key_counter <= key_counter_next;
        lost_counter <= lost_counter_next;
        byte_position <= byte_position_next;
        packet_dropped <= packet_dropped_next;
        indicator_bits <= indicator_bits_next;
        packet_intra <= packet_intra_next;
      end
    end
  end

endmodule

### hw/rtl/rhd_event_queue.sv
// Result register: holds the result set of one item and hands it out in order.
module rhd_event_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rhd_pkg::event_set_t                ev_set,
  input  logic [rhd_pkg::NUM_SLOTS-1:0]      ev_mask,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         event_kind,
  output logic [7:0]                         data_byte,
  output logic [rhd_pkg::OUT_ADDR_BITS-1:0]  address,
  output logic [2:0]                         status_code,
  output logic                               packet_keyframe,
  output logic [rhd_pkg::COUNT_BITS-1:0]     keyframe_count,
  output logic [rhd_pkg::COUNT_BITS-1:0]     lost_count,
  output logic                               last_result
);

  rhd_pkg::event_set_t           held;
  logic [rhd_pkg::NUM_SLOTS-1:0] mask;
  logic [rhd_pkg::NUM_SLOTS-1:0] low_bit, rest;
  rhd_pkg::event_t               cur;
  logic                          load, pop;

  assign low_bit = mask & (~mask + rhd_pkg::NUM_SLOTS'(1));
  assign rest = mask & ~low_bit;
  assign out_valid = |mask;
  assign pop = out_valid && out_ready;
  // take a new item when empty or when the last pending result leaves now
  assign in_ready = (mask == '0) || (out_ready && rest == '0);
  assign load = in_valid && in_ready;

  always_comb begin
    cur = '0;
    for (int i = 0; i < rhd_pkg::NUM_SLOTS; i++) begin
      if (low_bit[i]) begin
        cur = cur | held.slots[i];
      end
    end
  end

  assign event_kind = cur.kind;
  assign data_byte = cur.data;
  assign address = rhd_pkg::OUT_ADDR_BITS'(cur.addr);
  assign status_code = cur.stat;
  assign packet_keyframe = held.intra;
  assign keyframe_count = held.key_count;
  assign lost_count = held.lost_count;
  assign last_result = (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= ev_mask;
    end else if (pop) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= ev_set;
    end
  end

  a_pop_one: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> ($countones(mask) == $countones($past(mask)) - 1))
    else $error("result set did not shrink by one on a pop");

  a_drop_no_write: assert property (@(posedge clk) disable iff (rst)
    load |=> !(mask[rhd_pkg::SLOT_DROP] && (|mask[rhd_pkg::SLOT_END-1:rhd_pkg::SLOT_WRITE])))
    else $error("dropped packet also writes bytes");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (pop && last_result) |-> in_ready)
    else $error("queue not ready while its last result leaves");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(mask) && $stable(held)))
    else $error("pending results changed while stalled");

endmodule

### hw/rtl/rtp_h264_depacketizer_unit.sv
// Top level of the RTP H.264 depacketizer (single NAL and FU-A reassembly).
//
// Input channel (in_valid/in_ready) carries one RTP payload byte per item,
// framed by first_byte/last_byte, with the packet's sequence number and
// marker. Output channel (out_valid/out_ready) carries buffer events: byte
// writes with addresses, rewinds, frame-ready and error statuses, each with
// the current keyframe flag and the keyframe and loss counters. last_result
// marks the final event of one input byte; a byte may cause no event at all.
// cfg_write loads max_frame_bytes from cfg_data; write it only while idle.
//
// Latency: the first event of a byte appears the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one event
// (payload bytes) and out_ready is high; a byte with more events holds the
// input until the single result register drains them, one event per ready cycle.
// Up to seven events follow from one byte (rewind, start code, end of frame).
// Reset (rst, synchronous) clears all parser state and counters, empties the
// result register and loads max_frame_bytes with 524288.
// When the receiver stalls, the pending event holds and in_ready stays low
// while any event is pending.
module rtp_h264_depacketizer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         payload_byte,
  input  logic                               first_byte,
  input  logic                               last_byte,
  input  logic [15:0]                        sequence_number,
  input  logic                               marker_bit,
  input  logic                               cfg_write,
  input  logic [rhd_pkg::CFG_BITS-1:0]       cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         event_kind,
  output logic [7:0]                         data_byte,
  output logic [rhd_pkg::OUT_ADDR_BITS-1:0]  address,
  output logic [2:0]                         status_code,
  output logic                               packet_keyframe,
  output logic [15:0]                        keyframe_count,
  output logic [15:0]                        lost_count,
  output logic                               last_result
);

  rhd_pkg::event_set_t           ev_set;
  logic [rhd_pkg::NUM_SLOTS-1:0] ev_mask;
  logic                          take;

  assign take = in_valid && in_ready;

  rhd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .payload_byte    (payload_byte),
    .first_byte      (first_byte),
    .last_byte       (last_byte),
    .sequence_number (sequence_number),
    .marker_bit      (marker_bit),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .ev_set          (ev_set),
    .ev_mask         (ev_mask)
  );

  rhd_event_queue u_queue (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .ev_set          (ev_set),
    .ev_mask         (ev_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_kind      (event_kind),
    .data_byte       (data_byte),
    .address         (address),
    .status_code     (status_code),
    .packet_keyframe (packet_keyframe),
    .keyframe_count  (keyframe_count),
    .lost_count      (lost_count),
    .last_result     (last_result)
  );

endmodule
